// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the transfer sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Concurrent assertion on the usual clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/tts_pkg.sv =====
package tts_pkg;

  // Default data block size in bytes.
  localparam int unsigned BlockSizeDef = 512;

  // TFTP opcodes
  localparam logic [15:0] OP_RRQ  = 16'd1;
  localparam logic [15:0] OP_WRQ  = 16'd2;
  localparam logic [15:0] OP_DATA = 16'd3;
  localparam logic [15:0] OP_ACK  = 16'd4;

  // Fixed packet lengths
  localparam logic [9:0] LEN_HDR = 10'd4;
  localparam logic [9:0] LEN_ERR = 10'd5;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] opcode;
    logic [15:0] block_number;
    logic [9:0]  payload_len;
    logic        file_ok;
    logic [9:0]  read_len;
    logic        read_error;
  } in_t;

  typedef struct packed {
    kind_e       send_kind;
    logic [15:0] send_block;
    logic [9:0]  send_len;
    logic        close_conn;
    logic        do_write;
    logic        do_read;
  } out_t;

  typedef struct packed {
    logic        download_mode;
    logic [15:0] last_block;
    logic        transfer_done;
  } state_t;

endpackage

// ===== rtl/tts_step.sv =====
module tts_step #(
  parameter int unsigned BLOCK_SIZE = tts_pkg::BlockSizeDef
) (
  input  tts_pkg::in_t    item_i,
  input  tts_pkg::state_t state_i,
  output tts_pkg::out_t   result_o,
  output tts_pkg::state_t state_o
);

  localparam logic [10:0] BlockSizeW = 11'(BLOCK_SIZE);

  logic        blk_below;
  logic        blk_above;
  logic [15:0] ack_next;
  logic        read_short;
  logic        payload_short;
  logic [10:0] read_sat;
  logic [9:0]  data_len;
  logic        done_next;

  // Window bounds; the upper bound is formed in 17 bits and never wraps
  assign blk_below = item_i.block_number < state_i.last_block;
  assign blk_above = {1'b0, item_i.block_number} > ({1'b0, state_i.last_block} + 17'd1);
  assign ack_next  = item_i.block_number + 16'd1;

  // Compare lengths against the block size; saturate the read length to it
  assign read_short    = {1'b0, item_i.read_len} < BlockSizeW;
  assign payload_short = {1'b0, item_i.payload_len} < BlockSizeW;
  assign read_sat      = read_short ? {1'b0, item_i.read_len} : BlockSizeW;
  assign data_len      = 10'(read_sat + 11'(tts_pkg::LEN_HDR));
  assign done_next     = state_i.transfer_done | payload_short;

  // Decode one packet header against the transfer state
  always_comb begin
    result_o = '{send_kind: tts_pkg::KIND_ERROR, send_block: 16'd0,
                 send_len: tts_pkg::LEN_ERR, close_conn: 1'b1,
                 do_write: 1'b0, do_read: 1'b0};
    state_o  = state_i;
    unique case (item_i.opcode)
      tts_pkg::OP_RRQ: begin
        state_o = '{download_mode: 1'b1, last_block: 16'd0, transfer_done: 1'b0};
        if (item_i.file_ok && !item_i.read_error) begin
          result_o = '{send_kind: tts_pkg::KIND_DATA, send_block: 16'd1,
                       send_len: data_len, close_conn: 1'b0,
                       do_write: 1'b0, do_read: 1'b1};
          state_o.last_block    = 16'd1;
          state_o.transfer_done = read_short;
        end
      end
      tts_pkg::OP_ACK: begin
        if (state_i.download_mode && !blk_below && !blk_above) begin
          state_o.last_block = item_i.block_number;
          if (state_i.transfer_done) begin
            result_o = '{send_kind: tts_pkg::KIND_NONE, send_block: 16'd0,
                         send_len: 10'd0, close_conn: 1'b1,
                         do_write: 1'b0, do_read: 1'b0};
          end else if (!item_i.read_error) begin
            result_o = '{send_kind: tts_pkg::KIND_DATA, send_block: ack_next,
                         send_len: data_len, close_conn: 1'b0,
                         do_write: 1'b0, do_read: 1'b1};
            state_o.last_block    = ack_next;
            state_o.transfer_done = read_short;
          end
        end
      end
      tts_pkg::OP_WRQ: begin
        state_o = '{download_mode: 1'b0, last_block: 16'd0, transfer_done: 1'b0};
        if (item_i.file_ok) begin
          result_o = '{send_kind: tts_pkg::KIND_ACK, send_block: 16'd0,
                       send_len: tts_pkg::LEN_HDR, close_conn: 1'b0,
                       do_write: 1'b0, do_read: 1'b0};
        end
      end
      tts_pkg::OP_DATA: begin
        if (!state_i.download_mode && !blk_below) begin
          if (item_i.block_number == state_i.last_block) begin
            // duplicate: ack again, write nothing
            result_o = '{send_kind: tts_pkg::KIND_ACK, send_block: item_i.block_number,
                         send_len: tts_pkg::LEN_HDR, close_conn: state_i.transfer_done,
                         do_write: 1'b0, do_read: 1'b0};
          end else if (!blk_above && item_i.file_ok) begin
            result_o = '{send_kind: tts_pkg::KIND_ACK, send_block: item_i.block_number,
                         send_len: tts_pkg::LEN_HDR, close_conn: done_next,
                         do_write: 1'b1, do_read: 1'b0};
            state_o.last_block    = item_i.block_number;
            state_o.transfer_done = done_next;
          end
        end
      end
      default: begin
        result_o = result_o;
      end
    endcase
  end

endmodule

// ===== rtl/tftp_transfer_sequencer.sv =====
// TFTP server transfer sequencer.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one received
// packet header per handshake together with the file-store outcomes for it.
// Output channel (out_valid_o / out_ready_i / out_data_o) carries exactly one
// result per input: the packet to send, its block and length, and the close,
// write and read strobes.
// Path: an accepted input is held in the input register, and its result is
// then registered in the result register, which drives out_valid_o.
// Throughput: one packet per cycle while out_ready_i holds high; the input
// register and the result register form a two-entry pipeline, and the
// transfer state is updated as an item moves into the result register.
// Stall: while the result waits on out_ready_i, one more input is still taken
// into the input register; in_ready_o drops only when both registers are full.
// Reset: rst_ni clears both valid flags and the transfer state (upload mode,
// block zero, not finished).
`include "assert_macros.svh"

module tftp_transfer_sequencer #(
  parameter int unsigned BLOCK_SIZE = tts_pkg::BlockSizeDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tts_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tts_pkg::out_t out_data_o
);

  logic            in_valid_q;
  tts_pkg::in_t    in_item_q;
  logic            out_valid_q;
  tts_pkg::out_t   out_item_q;
  tts_pkg::state_t state_q;
  tts_pkg::state_t state_d;
  tts_pkg::out_t   result;
  logic            advance;

  // Move the held item forward when the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  tts_step #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_step (
    .item_i  (in_item_q),
    .state_i (state_q),
    .result_o(result),
    .state_o (state_d)
  );

  // Hold the accepted packet header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
  end

  // Register the result and commit the transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '{download_mode: 1'b0, last_block: 16'd0, transfer_done: 1'b0};
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // Checks
  `ASSERT_STD(a_write_is_ack,
    out_valid_o && out_data_o.do_write |-> out_data_o.send_kind == tts_pkg::KIND_ACK,
    "file write without an ack")
  `ASSERT_STD(a_data_reads,
    out_valid_o && out_data_o.send_kind == tts_pkg::KIND_DATA
      |-> out_data_o.do_read && !out_data_o.close_conn,
    "data packet without a read or with a close")
  `ASSERT_STD(a_data_err_keeps_state,
    advance && in_item_q.opcode == tts_pkg::OP_DATA
      && result.send_kind == tts_pkg::KIND_ERROR |=> $stable(state_q),
    "rejected data packet changed the transfer state")
  `ASSERT_STD(a_ready_only_when_full,
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i,
    "input stalled with a free slot")

endmodule
